// File: src/bdss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdss_pkg - shared types, register indexes and the sigmoid table
// Holds the Q0.16 sigmoid table, which is built at elaboration, plus the field
// types and configuration indexes that the decoder modules share.
// ----------------------------------------------------------------------------
package bdss_pkg;

  typedef logic signed [15:0] raw_t;    // signed Q4.12 network output
  typedef logic        [15:0] score_t;  // unsigned Q0.16
  typedef logic        [16:0] px_t;     // unsigned Q13.4 pixels
  typedef logic        [12:0] frame_t;  // frame size in pixels
  typedef logic        [1:0]  cfg_idx_t;
  typedef logic        [15:0] cfg_data_t;

  // configuration register indexes
  localparam cfg_idx_t CFG_FRAME_WIDTH     = 2'd0;
  localparam cfg_idx_t CFG_FRAME_HEIGHT    = 2'd1;
  localparam cfg_idx_t CFG_SCORE_THRESHOLD = 2'd2;

  // reset values of the configuration registers
  localparam frame_t RST_FRAME_WIDTH     = 13'd640;
  localparam frame_t RST_FRAME_HEIGHT    = 13'd480;
  localparam score_t RST_SCORE_THRESHOLD = 16'd32768;

  // largest frame size; frame_t and px_t are sized for it
  localparam int MAX_FRAME_SIZE = 4096;

  // normalized 1.0 in Q4.12
  localparam int COORD_ONE = 4096;

  localparam int SIG_ENTRIES = 257;
  typedef logic [15:0] sig_tab_t [0:SIG_ENTRIES-1];

  // Unsigned 64-bit quotient by shift and subtract, used only at elaboration
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, b}) begin
        rem    = rem - {1'b0, b};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Build round(65535 * sigmoid(-8 + k/16)) from powers of exp(-1/16) in Q60.
  function automatic sig_tab_t build_sig_table();
    sig_tab_t     tab;
    logic [63:0]  term;
    logic [63:0]  q;
    logic [63:0]  u [0:128];
    logic [127:0] prod;
    logic [63:0]  e;
    logic [63:0]  d;
    logic [63:0]  num;
    logic [63:0]  rnd;
    int           m;
    term = 64'd1 << 60;
    q    = 64'd1 << 60;
    // Taylor series for exp(-1/16), alternating signs
    for (int n = 1; n < 30; n++) begin
      if (term != 64'd0) begin
        term = udiv64(term, 64'd16 * 64'(n));
        if (n[0]) q = q - term;
        else      q = q + term;
      end
    end
    u[0] = 64'd1 << 60;
    for (int n = 1; n <= 128; n++) begin
      prod = 128'(u[n-1]) * 128'(q);
      u[n] = prod[123:60];
    end
    for (int k = 0; k < SIG_ENTRIES; k++) begin
      m   = (k < 128) ? 128 - k : k - 128;
      e   = u[m] >> 28;
      d   = (64'd1 << 32) + e;
      num = (k < 128) ? 64'd65535 * e : 64'd65535 * (64'd1 << 32);
      rnd = udiv64(64'd2 * num + d, 64'd2 * d);
      tab[k] = rnd[15:0];
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

// File: src/bdss_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdss_score - sigmoid score and detect flag
// Looks up two neighboring table entries from the offset logit, interpolates
// on its low byte and compares the score against the threshold.
// ----------------------------------------------------------------------------
module bdss_score (
  input  bdss_pkg::raw_t   logit,
  input  bdss_pkg::score_t threshold,
  output bdss_pkg::score_t score,
  output logic             detected
);
  import bdss_pkg::*;

  logic [15:0] uoff;
  logic [8:0]  idx_lo;
  logic [8:0]  idx_hi;
  logic [7:0]  frac;
  score_t      t_lo;
  score_t      t_hi;
  logic [15:0] diff;
  logic [23:0] prod;

  // offset the logit by 8.0 so it indexes from the table start
  assign uoff   = logit ^ 16'h8000;
  assign idx_lo = {1'b0, uoff[15:8]};
  assign idx_hi = idx_lo + 9'd1;
  assign frac   = uoff[7:0];

  // read both neighbors; the table rises, so the step is never negative
  assign t_lo = SIG_TABLE[idx_lo];
  assign t_hi = SIG_TABLE[idx_hi];
  assign diff = t_hi - t_lo;
  assign prod = {8'd0, diff} * {16'd0, frac};

  // truncating interpolation, then threshold compare
  assign score    = t_lo + prod[23:8];
  assign detected = (score >= threshold);

endmodule

// File: src/bdss_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdss_axis - one axis of the box decode
// Clamps centre and size to the unit range, forms both edges, scales them to
// Q.4 pixels and clamps them to the frame, then reports start and extent.
// ----------------------------------------------------------------------------
module bdss_axis (
  input  bdss_pkg::raw_t   center,
  input  bdss_pkg::raw_t   size,
  input  bdss_pkg::frame_t frame,
  output bdss_pkg::px_t    start_px,
  output bdss_pkg::px_t    span_px
);
  import bdss_pkg::*;

  // clamp a Q4.12 value to 0..1.0
  function automatic logic [12:0] clamp_unit(input raw_t v);
    logic [12:0] r;
    if (v < 16'sd0)                   r = 13'd0;
    else if (v > 16'(COORD_ONE))      r = 13'(COORD_ONE);
    else                              r = v[12:0];
    return r;
  endfunction

  // scale a normalized edge to Q.4 pixels and clamp to the frame
  function automatic px_t to_pixels(input logic signed [13:0] c, input frame_t f);
    logic signed [13:0] fs;
    logic signed [27:0] v;
    logic [18:0]        p;
    logic [18:0]        lim;
    px_t                r;
    fs  = $signed({1'b0, f});
    v   = c * fs;
    p   = v[26:8];
    lim = {2'b00, f, 4'b0000};
    if (v < 28'sd0)    r = '0;
    else if (p > lim)  r = lim[16:0];
    else               r = p[16:0];
    return r;
  endfunction

  logic [12:0]        c_cl;
  logic [12:0]        s_cl;
  logic [11:0]        half;
  logic signed [13:0] edge_lo;
  logic signed [13:0] edge_hi;
  px_t                px_lo;
  px_t                px_hi;

  assign c_cl = clamp_unit(center);
  assign s_cl = clamp_unit(size);
  assign half = s_cl[12:1];

  // edges at centre minus and plus half the size
  assign edge_lo = $signed({1'b0, c_cl}) - $signed({2'b00, half});
  assign edge_hi = $signed({1'b0, c_cl}) + $signed({2'b00, half});

  assign px_lo = to_pixels(edge_lo, frame);
  assign px_hi = to_pixels(edge_hi, frame);

  assign start_px = px_lo;
  assign span_px  = px_hi - px_lo;

endmodule

// File: src/box_decode_with_sigmoid_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_decode_with_sigmoid_score - box corner decode with a sigmoid score
//
// Input channel (in_valid/in_ready) takes one detection item: a confidence
// logit and the box centre and size, all signed Q4.12. Output channel
// (out_valid/out_ready) returns one result item per input: the Q0.16 score,
// the detect flag, and left, top, width and height in Q13.4 pixels.
// The config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes frame
// width, frame height and score threshold; it is always ready, and a write to
// an unused index is dropped. Write it only while no item is in flight.
// The item passes two registers: the input register takes it at the accept
// edge and the result register takes it once it has room, raising out_valid.
// Between them sit the table lookup, interpolation and two small multiplies
// per axis. Throughput is one item per cycle while out_ready stays high. When
// the receiver stalls the result register holds, the input register fills
// behind it and in_ready drops only when both are full.
// Reset empties both registers and loads 640 x 480 and a threshold of 0.5.
// ----------------------------------------------------------------------------
module box_decode_with_sigmoid_score (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  bdss_pkg::cfg_idx_t    cfg_index,
  input  bdss_pkg::cfg_data_t   cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bdss_pkg::raw_t        logit,
  input  bdss_pkg::raw_t        center_x,
  input  bdss_pkg::raw_t        center_y,
  input  bdss_pkg::raw_t        box_w,
  input  bdss_pkg::raw_t        box_h,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bdss_pkg::score_t      score,
  output bdss_pkg::px_t         left,
  output bdss_pkg::px_t         top,
  output bdss_pkg::px_t         box_width_px,
  output bdss_pkg::px_t         box_height_px,
  output logic                  detected
);
  import bdss_pkg::*;

  frame_t frame_width;
  frame_t frame_height;
  score_t score_threshold;

  logic   s1_valid;
  raw_t   s1_logit;
  raw_t   s1_cx;
  raw_t   s1_cy;
  raw_t   s1_w;
  raw_t   s1_h;
  logic   s2_ready;

  frame_t fw_lim;
  frame_t fh_lim;
  score_t score_c;
  logic   det_c;
  px_t    left_c;
  px_t    top_c;
  px_t    width_c;
  px_t    height_c;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= RST_FRAME_WIDTH;
      frame_height    <= RST_FRAME_HEIGHT;
      score_threshold <= RST_SCORE_THRESHOLD;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:     frame_width     <= cfg_data[12:0];
        CFG_FRAME_HEIGHT:    frame_height    <= cfg_data[12:0];
        CFG_SCORE_THRESHOLD: score_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake: each register advances when the one after it has room
  assign s2_ready = !out_valid || out_ready;
  assign in_ready = !s1_valid || s2_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_logit <= logit;
      s1_cx    <= center_x;
      s1_cy    <= center_y;
      s1_w     <= box_w;
      s1_h     <= box_h;
    end
  end

  // limit the frame size to the supported maximum
  assign fw_lim = (32'(frame_width) > 32'(MAX_FRAME_SIZE)) ?
                  13'(MAX_FRAME_SIZE) : frame_width;
  assign fh_lim = (32'(frame_height) > 32'(MAX_FRAME_SIZE)) ?
                  13'(MAX_FRAME_SIZE) : frame_height;

  bdss_score u_score (
    .logit      (s1_logit),
    .threshold  (score_threshold),
    .score      (score_c),
    .detected   (det_c)
  );

  bdss_axis u_axis_x (
    .center   (s1_cx),
    .size     (s1_w),
    .frame    (fw_lim),
    .start_px (left_c),
    .span_px  (width_c)
  );

  bdss_axis u_axis_y (
    .center   (s1_cy),
    .size     (s1_h),
    .frame    (fh_lim),
    .start_px (top_c),
    .span_px  (height_c)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      score         <= score_c;
      detected      <= det_c;
      left          <= left_c;
      top           <= top_c;
      box_width_px  <= width_c;
      box_height_px <= height_c;
    end
  end

`ifndef SYNTHESIS
  // a buffered item is never dropped while the result register is stalled
  a_hold_s1: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_ready |=> s1_valid)
    else $error("input register lost an item under stall");

  // a buffered item moves into the result register when there is room
  a_advance: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_ready |=> out_valid)
    else $error("item did not reach the result register");

  // with the input register empty, the block must be ready for a new item
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("in_ready low with an empty input register");
`endif

endmodule

// File: test/box_decode_with_sigmoid_score_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_decode_with_sigmoid_score_test - self-checking bench for the box decoder
// Drives detection items through the valid/ready input channel and checks
// every returned box and score against an in-bench decoder. The bench covers
// directed corner cases first, then random phases under several frame sizes
// and thresholds. Random gaps on both channels, one long receiver hold-off
// and drains before each register write are included.
// ----------------------------------------------------------------------------
module box_decode_with_sigmoid_score_test;
  import bdss_pkg::*;

  localparam int       FRAME_CAP      = 4096;
  localparam int       WATCHDOG_LIMIT = 1000;
  localparam int       SETTLE_CYCLES  = 4;
  localparam int       PHASE_ITEMS    = 130;
  localparam cfg_idx_t CFG_UNUSED     = 2'd3;

  typedef struct packed {
    raw_t logit;
    raw_t cx;
    raw_t cy;
    raw_t w;
    raw_t h;
  } box_in_t;

  typedef struct packed {
    score_t score;
    px_t    left;
    px_t    top;
    px_t    wpx;
    px_t    hpx;
    logic   det;
  } box_out_t;

  // Decoder copy, register shadows and the queue of boxes still due
  class box_ledger;
    int unsigned sig_lut [0:256];
    int unsigned frame_w;
    int unsigned frame_h;
    int unsigned thresh;
    box_out_t    boxes_due [$];
    int          errors;

    function new();
      logic [63:0]  term;
      logic [63:0]  q;
      logic [63:0]  pw [0:128];
      logic [127:0] prod;
      logic [63:0]  e;
      logic [63:0]  d;
      logic [63:0]  num;
      int           m;
      frame_w = 640;
      frame_h = 480;
      thresh  = 32768;
      errors  = 0;
      // exp(-1/16) in Q60, alternating Taylor terms
      term = 64'd1 << 60;
      q    = 64'd1 << 60;
      for (int n = 1; n < 30; n++) begin
        if (term != 64'd0) begin
          term = term / (64'd16 * 64'(n));
          if (n % 2 == 1) q = q - term;
          else q = q + term;
        end
      end
      // powers of exp(-1/16), truncated after each product
      pw[0] = 64'd1 << 60;
      for (int n = 1; n <= 128; n++) begin
        prod  = {64'd0, pw[n-1]} * {64'd0, q};
        pw[n] = prod[123:60];
      end
      // round half up of 65535 * sigmoid(-8 + k/16)
      for (int k = 0; k <= 256; k++) begin
        m   = (k < 128) ? 128 - k : k - 128;
        e   = pw[m] >> 28;
        d   = (64'd1 << 32) + e;
        num = (k < 128) ? 64'd65535 * e : 64'd65535 * (64'd1 << 32);
        sig_lut[k] = int'((64'd2 * num + d) / (64'd2 * d));
      end
    endfunction

    function void set_reg(cfg_idx_t idx, cfg_data_t data);
      case (idx)
        CFG_FRAME_WIDTH: begin
          frame_w = data[12:0];
        end
        CFG_FRAME_HEIGHT: begin
          frame_h = data[12:0];
        end
        CFG_SCORE_THRESHOLD: begin
          thresh = data;
        end
        default: begin
        end
      endcase
    endfunction

    function int unit_clamp(int v);
      return (v < 0) ? 0 : ((v > COORD_ONE) ? COORD_ONE : v);
    endfunction

    // Scale a normalized coordinate to Q.4 pixels and clamp to the frame
    function int unsigned scale_px(int c, int unsigned frame);
      longint v;
      longint lim;
      v   = longint'(c) * longint'(frame);
      lim = longint'(frame) * 16;
      if (v < 0) return 0;
      v = v >>> 8;
      return int'((v > lim) ? lim : v);
    endfunction

    function box_out_t decode_box(box_in_t b);
      box_out_t    r;
      logic [15:0] uoff;
      int unsigned idx;
      int unsigned frac;
      int unsigned sc;
      int          cx;
      int          cy;
      int          hw;
      int          hh;
      int unsigned fw;
      int unsigned fh;
      int unsigned x0;
      int unsigned x1;
      int unsigned y0;
      int unsigned y1;
      // interpolate the sigmoid between neighboring entries
      uoff = b.logit + 16'h8000;
      idx  = uoff[15:8];
      frac = uoff[7:0];
      sc   = sig_lut[idx] + (((sig_lut[idx+1] - sig_lut[idx]) * frac) >> 8);
      // clamp centre and size, then form corners
      cx = unit_clamp(int'(b.cx));
      cy = unit_clamp(int'(b.cy));
      hw = unit_clamp(int'(b.w)) >> 1;
      hh = unit_clamp(int'(b.h)) >> 1;
      fw = (frame_w > FRAME_CAP) ? FRAME_CAP : frame_w;
      fh = (frame_h > FRAME_CAP) ? FRAME_CAP : frame_h;
      x0 = scale_px(cx - hw, fw);
      x1 = scale_px(cx + hw, fw);
      y0 = scale_px(cy - hh, fh);
      y1 = scale_px(cy + hh, fh);
      r.score = sc[15:0];
      r.left  = x0[16:0];
      r.top   = y0[16:0];
      r.wpx   = 17'(x1 - x0);
      r.hpx   = 17'(y1 - y0);
      r.det   = (sc >= thresh);
      return r;
    endfunction

    function void note_item(box_in_t b);
      boxes_due.push_back(decode_box(b));
    endfunction

    function void check_item(box_out_t got);
      box_out_t want;
      if (boxes_due.size() == 0) begin
        $error("result with no item outstanding: score %0d left %0d", got.score, got.left);
        errors++;
        return;
      end
      want = boxes_due.pop_front();
      if (got.score != want.score) begin
        $error("score: expected %0d, got %0d", want.score, got.score);
        errors++;
      end
      if (got.left != want.left) begin
        $error("left: expected %0d, got %0d", want.left, got.left);
        errors++;
      end
      if (got.top != want.top) begin
        $error("top: expected %0d, got %0d", want.top, got.top);
        errors++;
      end
      if (got.wpx != want.wpx) begin
        $error("box_width_px: expected %0d, got %0d", want.wpx, got.wpx);
        errors++;
      end
      if (got.hpx != want.hpx) begin
        $error("box_height_px: expected %0d, got %0d", want.hpx, got.hpx);
        errors++;
      end
      if (got.det != want.det) begin
        $error("detected: expected %0d, got %0d", want.det, got.det);
        errors++;
      end
    endfunction

    function int pending();
      return boxes_due.size();
    endfunction
  endclass

  logic      clk        = 1'b0;
  logic      rst        = 1'b1;
  logic      cfg_valid  = 1'b0;
  logic      cfg_ready;
  cfg_idx_t  cfg_index  = CFG_FRAME_WIDTH;
  cfg_data_t cfg_data   = '0;
  logic      in_valid   = 1'b0;
  logic      in_ready;
  raw_t      logit      = '0;
  raw_t      center_x   = '0;
  raw_t      center_y   = '0;
  raw_t      box_w      = '0;
  raw_t      box_h      = '0;
  logic      out_valid;
  logic      out_ready  = 1'b0;
  score_t    score;
  px_t       left;
  px_t       top;
  px_t       box_width_px;
  px_t       box_height_px;
  logic      detected;

  box_ledger ledger;
  int        max_in_gap  = 17;
  int        max_out_gap = 17;
  int        rx_hold     = 0;
  int        quiet_cycles = 0;

  box_decode_with_sigmoid_score dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .logit         (logit),
    .center_x      (center_x),
    .center_y      (center_y),
    .box_w         (box_w),
    .box_h         (box_h),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .score         (score),
    .left          (left),
    .top           (top),
    .box_width_px  (box_width_px),
    .box_height_px (box_height_px),
    .detected      (detected)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // End the run when no channel moves an item for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Write one register; valid stays high for a following write
  task automatic cfg_write(input cfg_idx_t idx, input cfg_data_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    ledger.set_reg(idx, data);
  endtask

  task automatic program_regs(input cfg_data_t fw, input cfg_data_t fh, input cfg_data_t thr);
    cfg_write(CFG_FRAME_WIDTH, fw);
    cfg_write(CFG_FRAME_HEIGHT, fh);
    cfg_write(CFG_SCORE_THRESHOLD, thr);
    cfg_write(CFG_UNUSED, cfg_data_t'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Wait until every due box has come back, then let the pipe settle
  task automatic drain();
    while (ledger.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer one item after a random gap; valid stays high across back-to-back items
  task automatic send_box(input box_in_t b);
    int gap;
    gap = $urandom_range(0, max_in_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    logit      <= b.logit;
    center_x   <= b.cx;
    center_y   <= b.cy;
    box_w      <= b.w;
    box_h      <= b.h;
    do @(posedge clk); while (!in_ready);
    ledger.note_item(b);
  endtask

  function automatic raw_t pick_coord();
    case ($urandom_range(0, 9))
      0: return raw_t'($urandom);
      1: return $urandom_range(0, 1) ? raw_t'(COORD_ONE) : raw_t'(0);
      default: return raw_t'(int'($urandom_range(0, 4864)) - 384);
    endcase
  endfunction

  function automatic raw_t pick_size();
    case ($urandom_range(0, 9))
      0: return raw_t'($urandom);
      1: return raw_t'(COORD_ONE - 1 + int'($urandom_range(0, 2)));
      default: return raw_t'($urandom_range(0, 4200));
    endcase
  endfunction

  task automatic send_random(input int count);
    box_in_t b;
    for (int n = 0; n < count; n++) begin
      // now and then pause the sender until the block is empty
      if ($urandom_range(0, 59) == 0) begin
        in_valid <= 1'b0;
        drain();
      end
      b.logit = raw_t'($urandom);
      b.cx    = pick_coord();
      b.cy    = pick_coord();
      b.w     = pick_size();
      b.h     = pick_size();
      send_box(b);
    end
    in_valid <= 1'b0;
  endtask

  task automatic run_phase(input cfg_data_t fw, input cfg_data_t fh, input cfg_data_t thr,
                           input int gap_in, input int gap_out, input int hold);
    drain();
    program_regs(fw, fh, thr);
    max_in_gap  = gap_in;
    max_out_gap = gap_out;
    rx_hold     = hold;
    send_random(PHASE_ITEMS);
  endtask

  // Receiver: random stalls, one long hold-off on request, check every result
  initial begin
    int       gap;
    box_out_t got;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_hold > 0) begin
        gap     = rx_hold;
        rx_hold = 0;
      end else begin
        gap = $urandom_range(0, max_out_gap);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.score = score;
      got.left  = left;
      got.top   = top;
      got.wpx   = box_width_px;
      got.hpx   = box_height_px;
      got.det   = detected;
      ledger.check_item(got);
    end
  end

  initial begin
    ledger = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items under the reset frame and threshold
    send_box('{16'sh8000, 16'sh0800, 16'sh0800, 16'sh1000, 16'sh1000});
    send_box('{16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000});
    send_box('{16'sh0000, 16'sh1000, 16'sh1000, 16'sh1000, 16'sh1000});
    send_box('{16'shFFFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF});
    send_box('{16'sh00FF, 16'sh0100, 16'sh0F00, 16'sh0801, 16'sh0003});
    send_box('{16'shFF00, 16'sh0400, 16'sh0C00, 16'sh0C00, 16'sh0C00});
    send_box('{16'sh0080, 16'sh1001, 16'shFFFF, 16'sh1001, 16'shFFFF});
    send_box('{16'sh8001, 16'sh0001, 16'sh0FFF, 16'sh0001, 16'sh0FFF});
    send_box('{16'sh7F00, 16'sh0555, 16'sh0AAA, 16'sh0333, 16'sh0777});
    send_box('{16'sh4000, 16'sh2000, 16'shE000, 16'sh2000, 16'shE000});
    send_box('{16'shC000, 16'sh0800, 16'sh0800, 16'sh0002, 16'sh0002});
    send_box('{16'sh0001, 16'sh0000, 16'sh1000, 16'sh1000, 16'sh0000});
    send_box('{16'sh00FF, 16'sh0FFF, 16'sh0001, 16'sh0FFF, 16'sh0001});
    send_box('{16'sh8100, 16'sh0800, 16'sh0800, 16'sh7FFF, 16'sh8000});
    in_valid <= 1'b0;

    // Random phases across frame sizes, thresholds and idling patterns
    run_phase(16'd1, 16'd1, 16'd0, 17, 17, 0);
    run_phase(16'd4096, 16'd4096, 16'd65535, 0, 0, 0);
    run_phase(16'hFFFF, 16'd4097, cfg_data_t'($urandom), 0, 17, 150);
    run_phase(16'd0, 16'd0, cfg_data_t'($urandom), 17, 0, 0);
    run_phase(cfg_data_t'($urandom_range(1, 4096)), cfg_data_t'($urandom_range(1, 4096)),
              cfg_data_t'($urandom), 17, 17, 0);
    run_phase(16'd640, 16'd480, 16'd32768, 3, 1, 0);
    run_phase(cfg_data_t'($urandom), cfg_data_t'($urandom), cfg_data_t'($urandom), 17, 5, 0);
    run_phase(cfg_data_t'($urandom_range(1, 64)), cfg_data_t'($urandom_range(4000, 4096)),
              cfg_data_t'($urandom_range(30000, 36000)), 0, 0, 0);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
